### src/pcs_pkg.sv
// Package for the palette nearest-color search core: sizes, codes and the
// packed item types shared by the front, back and top-level modules.
// No dependencies.
package pcs_pkg;

  // Palette capacity (2..256).
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);

  // Fixed field widths.
  localparam int SIZE_W   = 9;
  localparam int COLOR_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int SQ_W     = 2 * COLOR_W;
  localparam int DIST_W   = 18;
  localparam int ENTRY_W  = 3 * COLOR_W;

  // Command queue between front and back.
  localparam int CMD_DEPTH  = 4;
  localparam int CPTR_W     = $clog2(CMD_DEPTH);
  localparam int CCNT_W     = $clog2(CMD_DEPTH + 1);

  // Result queue at the output.
  localparam int RES_DEPTH  = 2;
  localparam int RPTR_W     = $clog2(RES_DEPTH);
  localparam int RCNT_W     = $clog2(RES_DEPTH + 1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    logic               req_type;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

endpackage

### src/pcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/pcs_front.sv
// Front end: accepts requests, drops writes outside the palette in use and
// queues the rest for the back end. Depends on pcs_pkg.
module pcs_front import pcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  in_item_t          req,
  input  logic [SIZE_W-1:0] palette_size,
  input  logic              cmd_pop,
  output cmd_q_t            cmd_q
);

  cmd_t              fifo [CMD_DEPTH];
  logic [CPTR_W-1:0] wr_ptr;
  logic [CPTR_W-1:0] rd_ptr;
  logic [CCNT_W-1:0] count;
  logic              keep;
  logic              enq;
  cmd_t              cmd_in;

  assign full = (count == CCNT_W'(CMD_DEPTH));

  // A write beyond the size in use never reaches the store.
  assign keep = (op_t'(req.req_type) == OP_SEARCH) ||
                (SIZE_W'(req.entry_index) < palette_size);
  assign enq  = push && !full && keep;

  always_comb begin
    cmd_in.op    = op_t'(req.req_type);
    cmd_in.idx   = req.entry_index;
    cmd_in.red   = req.red;
    cmd_in.green = req.green;
    cmd_in.blue  = req.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  assign cmd_q.valid = (count != '0);
  assign cmd_q.cmd   = fifo[rd_ptr];

endmodule

### src/pcs_back.sv
// Back end: executes queued palette writes and scans the palette for searches
// through a three-stage read/square/compare pipeline. Depends on pcs_pkg, pcs_ram.
module pcs_back import pcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_q_t            cmd_q,
  output logic              cmd_pop,
  input  logic [SIZE_W-1:0] palette_size,
  output out_item_t         result,
  output logic              empty,
  input  logic              pop
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [SIZE_W-1:0]      cnt;
  logic [COLOR_W-1:0]     q_red;
  logic [COLOR_W-1:0]     q_green;
  logic [COLOR_W-1:0]     q_blue;
  logic [MAX_ENTRIES-1:0] valid_bits;

  logic                   ram_we;
  logic                   issue;
  logic                   start;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [ENTRY_W-1:0]     rd_data;

  logic                   s1_vld;
  logic [IDX_W-1:0]       s1_idx;
  logic                   ent_ok;
  logic [ENTRY_W-1:0]     ent;
  logic [COLOR_W-1:0]     dr;
  logic [COLOR_W-1:0]     dg;
  logic [COLOR_W-1:0]     db;

  logic                   s2_vld;
  logic [IDX_W-1:0]       s2_idx;
  logic [SQ_W-1:0]        sq_r;
  logic [SQ_W-1:0]        sq_g;
  logic [SQ_W-1:0]        sq_b;
  logic [DIST_W-1:0]      sum_sq;

  logic                   hit;
  logic [DIST_W-1:0]      best_d;
  logic [IDX_W-1:0]       best_i;

  out_item_t              res_mem [RES_DEPTH];
  out_item_t              res_item;
  logic [RPTR_W-1:0]      res_wr_ptr;
  logic [RPTR_W-1:0]      res_rd_ptr;
  logic [RCNT_W-1:0]      res_count;
  logic                   res_push;
  logic                   res_pop;

  assign issue   = (state == ST_SCAN) && (cnt < palette_size);
  assign rd_addr = cnt[IDX_W-1:0];
  assign wr_data = {cmd_q.cmd.red, cmd_q.cmd.green, cmd_q.cmd.blue};
  assign start   = (state == ST_IDLE) && cmd_pop && (cmd_q.cmd.op == OP_SEARCH);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    res_push   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_q.valid) begin
          if (cmd_q.cmd.op == OP_WRITE) begin
            cmd_pop = 1'b1;
            ram_we  = 1'b1;
          end else if (res_count != RCNT_W'(RES_DEPTH)) begin
            // Only start when the result has a slot waiting for it.
            cmd_pop    = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Best is final once both pipeline stages are empty.
        if (!s1_vld && !s2_vld) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  pcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cmd_q.cmd.idx[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage 1: entries never written since reset read as black.
  assign ent = ent_ok ? rd_data : '0;

  always_comb begin
    dr = (ent[23:16] > q_red)   ? (ent[23:16] - q_red)   : (q_red   - ent[23:16]);
    dg = (ent[15:8]  > q_green) ? (ent[15:8]  - q_green) : (q_green - ent[15:8]);
    db = (ent[7:0]   > q_blue)  ? (ent[7:0]   - q_blue)  : (q_blue  - ent[7:0]);
  end

  // Stage 2: sum of squares.
  assign sum_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
      s1_vld     <= 1'b0;
      s2_vld     <= 1'b0;
      hit        <= 1'b0;
    end else begin
      state  <= state_next;
      s1_vld <= issue;
      s2_vld <= s1_vld;
      if (ram_we) begin
        valid_bits[cmd_q.cmd.idx[IDX_W-1:0]] <= 1'b1;
      end
      if (start) begin
        hit <= 1'b0;
      end else if (s2_vld && (!hit || sum_sq < best_d)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt     <= '0;
      q_red   <= cmd_q.cmd.red;
      q_green <= cmd_q.cmd.green;
      q_blue  <= cmd_q.cmd.blue;
      best_d  <= '0;
      best_i  <= '0;
    end else begin
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (s2_vld && (!hit || sum_sq < best_d)) begin
        best_d <= sum_sq;
        best_i <= s2_idx;
      end
    end
    ent_ok <= valid_bits[rd_addr];
    s1_idx <= rd_addr;
    s2_idx <= s1_idx;
    sq_r   <= dr * dr;
    sq_g   <= dg * dg;
    sq_b   <= db * db;
  end

  // Result queue.
  always_comb begin
    res_item.found         = hit;
    res_item.best_index    = INDEX_W'(best_i);
    res_item.best_distance = best_d;
  end

  assign empty   = (res_count == '0);
  assign res_pop = pop && !empty;
  assign result  = res_mem[res_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= res_wr_ptr + 1'b1;
      end
      if (res_pop) begin
        res_rd_ptr <= res_rd_ptr + 1'b1;
      end
      case ({res_push, res_pop})
        2'b10:   res_count <= res_count + 1'b1;
        2'b01:   res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr_ptr] <= res_item;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_count != RCNT_W'(RES_DEPTH))
    else $error("result pushed into a full result queue");

  assert property (@(posedge clk) disable iff (rst)
    res_push |-> hit == (palette_size != '0))
    else $error("found flag disagrees with palette size");

  assert property (@(posedge clk) disable iff (rst)
    (res_push && !hit) |-> (best_d == '0 && best_i == '0))
    else $error("empty search left nonzero index or distance");

  assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> state != ST_IDLE)
    else $error("pipeline still busy after search finished");

endmodule

### src/palette_nearest_color_search_core.sv
// Top level of the palette nearest-color search core: palette size register,
// front end and back end. Depends on pcs_pkg, pcs_front, pcs_back.
//
// Usage:
//   Requests enter through push/full; a beat is taken when push is high and
//   full is low. A write request stores red/green/blue at entry_index when
//   the index is below palette_size; writes beyond it are dropped and writes
//   never produce a result. A search request produces one result: the lowest
//   index with the least squared RGB distance, that distance and a found flag.
//   Results leave through empty/pop; the oldest is on result while empty is
//   low and is taken when pop is high.
//   palette_size is set through cfg_wr_en/cfg_wr_data; the user must write it
//   only while the core is idle, which the core itself does not enforce. Values
//   above the palette capacity are ignored. The back end executes a write
//   straight from idle; a search scans the store, reading one palette entry per
//   cycle, then drains the pipeline before its result is queued. A four-deep
//   request queue and a two-deep result queue decouple both sides.
//   Reset clears the size to 0 and makes every palette entry read as black.
//   When pop stays low, finished results wait in the result queue; once it is
//   full the back end holds the next search and requests back up into full.
module palette_nearest_color_search_core import pcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  in_item_t          req,
  output logic              empty,
  input  logic              pop,
  output out_item_t         result,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data
);

  logic [SIZE_W-1:0] palette_size;
  cmd_q_t            cmd_q;
  logic              cmd_pop;

  // Drop sizes beyond capacity, keep the previous value.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= '0;
    end else if (cfg_wr_en && (cfg_wr_data <= SIZE_W'(MAX_ENTRIES))) begin
      palette_size <= cfg_wr_data;
    end
  end

  pcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req          (req),
    .palette_size (palette_size),
    .cmd_pop      (cmd_pop),
    .cmd_q        (cmd_q)
  );

  pcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_q        (cmd_q),
    .cmd_pop      (cmd_pop),
    .palette_size (palette_size),
    .result       (result),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
